@@ rtl/core/hpsc_pkg.sv @@
package hpsc_pkg;

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned FRONT_STAGES = 10;
	localparam int unsigned BACK_STAGES = 3;
	localparam int unsigned LATENCY = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

	localparam logic [31:0] HUM_MAX = 32'd419430400;
	localparam logic [19:0] PRES_MAX = 20'hFFFFF;

	typedef enum logic [2:0] {
		REG_CAL_T   = 3'd0,
		REG_CAL_PL  = 3'd1,
		REG_CAL_PH  = 3'd2,
		REG_CAL_MIX = 3'd3,
		REG_CAL_HUM = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [19:0]        pressure_pa;
		logic               pressure_valid;
		logic [16:0]        humidity_q10;
	} result_t;

	typedef struct packed {
		logic [31:0] hum;
		logic [47:0] mix;
		logic [63:0] pres_hi;
		logic [63:0] pres_lo;
		logic [47:0] temp;
	} cal_t;

	// results that ride alongside the divider
	typedef struct packed {
		logic [14:0] temperature_centi;
		logic [16:0] humidity_q10;
		logic        div_zero;
	} side_t;

	function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
		sra = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx12(input logic [11:0] v);
		sx12 = {{20{v[11]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		sx8 = {{24{v[7]}}, v};
	endfunction

endpackage

@@ rtl/core/hpsc_front.sv @@
module hpsc_front import hpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  sample_t     sample,
	input  cal_t        cal,
	output logic        out_valid,
	output logic [31:0] dividend,
	output logic [31:0] divisor,
	output logic        dbl,
	output side_t       side
);

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p8_unused_guard;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {16'd0, cal.temp[15:0]};
	assign t2 = sx16(cal.temp[31:16]);
	assign t3 = sx16(cal.temp[47:32]);
	assign p1 = {16'd0, cal.pres_lo[15:0]};
	assign p2 = sx16(cal.pres_lo[31:16]);
	assign p3 = sx16(cal.pres_lo[47:32]);
	assign p4 = sx16(cal.pres_lo[63:48]);
	assign p5 = sx16(cal.pres_hi[15:0]);
	assign p6 = sx16(cal.pres_hi[31:16]);
	assign p8_unused_guard = '0;
	assign h1 = {24'd0, cal.mix[23:16]};
	assign h2 = sx16(cal.mix[39:24]);
	assign h3 = {24'd0, cal.mix[47:40]};
	assign h4 = sx12(cal.hum[11:0]);
	assign h5 = sx12(cal.hum[23:12]);
	assign h6 = sx8(cal.hum[31:24]);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0;
		end else begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= vld_s7;
			vld_s9 <= vld_s8; vld_s10 <= vld_s9;
		end
	end

	// stage 1: temperature products
	logic [31:0] ta, tb;
	logic [31:0] tm1_s1, tbb_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6;
	logic [15:0] adch_s1, adch_s2, adch_s3, adch_s4;

	assign ta = {15'd0, sample.raw_temperature[19:3]} - (t1 << 1);
	assign tb = {16'd0, sample.raw_temperature[19:4]} - t1;

	// stage 2..3: fine temperature
	logic [31:0] tv1_s2, tm2_s2, tf_s3;

	// stage 4: temperature result, first pressure and humidity products
	logic [31:0] pv1, pq, hx, temp5, tr;
	logic [14:0] tc;
	logic [14:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic [31:0] qq_s4, mp5_s4, mp2_s4, mh5_s4, mh6_s4, mh3_s4;

	assign pv1 = sra(tf_s3, 1) - 32'd64000;
	assign pq = sra(pv1, 2);
	assign hx = tf_s3 - 32'd76800;
	assign temp5 = (tf_s3 << 2) + tf_s3 + 32'd128;
	assign tr = sra(temp5, 8);

	always_comb begin
		if ($signed(tr) < -32'sd4000)
			tc = 15'($signed(-16'sd4000));
		else if ($signed(tr) > 32'sd8500)
			tc = 15'd8500;
		else
			tc = tr[14:0];
	end

	// stage 5
	logic [31:0] v2a_s5, mp3_s5, mp5_s5, mp2_s5, ha_s5, hbm_s5;

	// stage 6
	logic [31:0] v2_s6, px_s6, hmb_s6, ha_s6;

	// stage 7
	logic [31:0] pm_s7, pnum_s7, hxx_s7;

	// stage 8
	logic [31:0] num_s8, den_s8, hxx_s8, hss_s8;
	logic        dbl_s8;

	// stage 9
	logic [31:0] num_s9, den_s9, hxx_s9, hm_s9;
	logic        dbl_s9;

	// stage 10
	logic [31:0] num_s10, den_s10, hx2;
	logic        dbl_s10;
	logic [16:0] hq;
	logic [16:0] hum_s10;

	assign hx2 = hxx_s9 - sra(hm_s9, 4);

	always_comb begin
		if (hx2[31])
			hq = '0;
		else if (hx2 > HUM_MAX)
			hq = HUM_MAX[28:12];
		else
			hq = hx2[28:12];
	end

	always_ff @(posedge clk) begin
		// s1
		tm1_s1 <= ta * t2;
		tbb_s1 <= tb * tb;
		adcp_s1 <= sample.raw_pressure;
		adch_s1 <= sample.raw_humidity;
		// s2
		tv1_s2 <= sra(tm1_s1, 11);
		tm2_s2 <= sra(tbb_s1, 12) * t3;
		adcp_s2 <= adcp_s1;
		adch_s2 <= adch_s1;
		// s3
		tf_s3 <= tv1_s2 + sra(tm2_s2, 14);
		adcp_s3 <= adcp_s2;
		adch_s3 <= adch_s2;
		// s4
		tc_s4 <= tc;
		qq_s4 <= pq * pq;
		mp5_s4 <= pv1 * p5;
		mp2_s4 <= p2 * pv1;
		mh5_s4 <= h5 * hx;
		mh6_s4 <= hx * h6;
		mh3_s4 <= hx * h3;
		adcp_s4 <= adcp_s3;
		adch_s4 <= adch_s3;
		// s5
		tc_s5 <= tc_s4;
		v2a_s5 <= sra(qq_s4, 11) * p6;
		mp3_s5 <= p3 * sra(qq_s4, 13);
		mp5_s5 <= mp5_s4;
		mp2_s5 <= mp2_s4;
		ha_s5 <= sra((({16'd0, adch_s4} << 14) - (h4 << 20) - mh5_s4) + 32'd16384, 15);
		hbm_s5 <= sra(mh6_s4, 10) * (sra(mh3_s4, 11) + 32'd32768);
		adcp_s5 <= adcp_s4;
		// s6
		tc_s6 <= tc_s5;
		v2_s6 <= sra(v2a_s5 + (mp5_s5 << 1), 2) + (p4 << 16);
		px_s6 <= 32'd32768 + sra(sra(mp3_s5, 3) + sra(mp2_s5, 1), 18);
		hmb_s6 <= (sra(hbm_s5, 10) + 32'd2097152) * h2 + 32'd8192;
		ha_s6 <= ha_s5;
		adcp_s6 <= adcp_s5;
		// s7
		tc_s7 <= tc_s6;
		pm_s7 <= px_s6 * p1;
		pnum_s7 <= ((32'd1048576 - {12'd0, adcp_s6}) - sra(v2_s6, 12)) * 32'd3125
			+ p8_unused_guard;
		hxx_s7 <= ha_s6 * sra(hmb_s6, 14);
		// s8
		tc_s8 <= tc_s7;
		den_s8 <= sra(pm_s7, 15);
		dbl_s8 <= pnum_s7[31];
		num_s8 <= pnum_s7[31] ? pnum_s7 : (pnum_s7 << 1);
		hxx_s8 <= hxx_s7;
		hss_s8 <= sra(hxx_s7, 15) * sra(hxx_s7, 15);
		// s9
		tc_s9 <= tc_s8;
		den_s9 <= den_s8;
		dbl_s9 <= dbl_s8;
		num_s9 <= num_s8;
		hxx_s9 <= hxx_s8;
		hm_s9 <= sra(hss_s8, 7) * h1;
		// s10
		tc_s10 <= tc_s9;
		den_s10 <= den_s9;
		dbl_s10 <= dbl_s9;
		num_s10 <= num_s9;
		hum_s10 <= hq;
	end

	assign out_valid = vld_s10;
	assign dividend = num_s10;
	assign divisor = den_s10;
	assign dbl = dbl_s10;
	assign side.temperature_centi = tc_s10;
	assign side.humidity_q10 = hum_s10;
	assign side.div_zero = (den_s10 == '0);

endmodule

@@ rtl/core/hpsc_div.sv @@
module hpsc_div import hpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	input  logic        in_dbl,
	input  side_t       in_side,
	output logic        out_valid,
	output logic [31:0] quotient,
	output logic        out_dbl,
	output side_t       out_side
);

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] quo;
		logic [31:0] den;
		logic        dbl;
		side_t       side;
	} div_st_t;

	// restoring divider, one quotient bit per stage
	div_st_t st_s [DIV_STEPS+1];
	logic    vld_s [DIV_STEPS+1];

	always_comb begin
		st_s[0].rem = '0;
		st_s[0].num = dividend;
		st_s[0].quo = '0;
		st_s[0].den = divisor;
		st_s[0].dbl = in_dbl;
		st_s[0].side = in_side;
		vld_s[0] = in_valid;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [32:0] trial;
		logic        take;

		assign trial = {st_s[i].rem, st_s[i].num[31]};
		assign take = (trial >= {1'b0, st_s[i].den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			st_s[i+1].rem <= take ? 32'(trial - {1'b0, st_s[i].den}) : trial[31:0];
			st_s[i+1].num <= st_s[i].num << 1;
			st_s[i+1].quo <= {st_s[i].quo[30:0], take};
			st_s[i+1].den <= st_s[i].den;
			st_s[i+1].dbl <= st_s[i].dbl;
			st_s[i+1].side <= st_s[i].side;
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
	assign quotient = st_s[DIV_STEPS].quo;
	assign out_dbl = st_s[DIV_STEPS].dbl;
	assign out_side = st_s[DIV_STEPS].side;

endmodule

@@ rtl/core/hpsc_back.sv @@
module hpsc_back import hpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] quotient,
	input  logic        in_dbl,
	input  side_t       in_side,
	input  cal_t        cal,
	output logic        out_valid,
	output result_t     result
);

	logic [31:0] p7, p8, p9;
	assign p7 = sx16(cal.pres_hi[47:32]);
	assign p8 = sx16(cal.pres_hi[63:48]);
	assign p9 = sx16(cal.mix[15:0]);

	logic vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	logic [31:0] p;
	assign p = in_dbl ? {quotient[30:0], 1'b0} : quotient;

	logic [31:0] p_s1, sq_s1, m8_s1, p_s2, m9_s2, c2_s2;
	side_t       side_s1, side_s2;
	result_t     res_s3;

	logic [31:0] corr;
	logic [33:0] pres;
	logic [19:0] pa;

	assign corr = sra(sra(m9_s2, 12) + c2_s2 + p7, 4);
	assign pres = 34'($signed({2'b00, p_s2}) + $signed({{2{corr[31]}}, corr}));

	always_comb begin
		if (pres[33])
			pa = '0;
		else if (pres > {14'd0, PRES_MAX})
			pa = PRES_MAX;
		else
			pa = pres[19:0];
	end

	always_ff @(posedge clk) begin
		p_s1 <= p;
		sq_s1 <= (p >> 3) * (p >> 3);
		m8_s1 <= (p >> 2) * p8;
		side_s1 <= in_side;

		p_s2 <= p_s1;
		m9_s2 <= p9 * (sq_s1 >> 13);
		c2_s2 <= sra(m8_s1, 13);
		side_s2 <= side_s1;

		res_s3.temperature_centi <= $signed(side_s2.temperature_centi);
		res_s3.humidity_q10 <= side_s2.humidity_q10;
		res_s3.pressure_valid <= !side_s2.div_zero;
		res_s3.pressure_pa <= side_s2.div_zero ? '0 : pa;
	end

	assign out_valid = vld_s3;
	assign result = res_s3;

endmodule

@@ rtl/core/humidity_pressure_sensor_compensation.sv @@
// Environmental sensor compensation: temperature, pressure and humidity.
// Input: raise start with a raw sample; busy is always low, so one sample
// item is taken every cycle start is high.
// Output: done pulses for one cycle with the compensated result item; the
// receiver must take it then, there is no backpressure.
// Pipeline from accept to done: 10 front stages of multiplies,
// 32 divider stages at one quotient bit each, 3 correction stages.
// Throughput: one item per cycle, set by the fully pipelined divider.
// Calibration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 temperature, 1/2 pressure low/high, 3 mixed, 4 humidity);
// other indexes are ignored. Write calibration only while no item is in
// flight. A zero pressure divisor gives pressure_valid low and 0 Pa.
// Reset: arst_n clears the calibration to zero and empties the pipeline;
// no done pulse follows until a new item is taken.
module humidity_pressure_sensor_compensation import hpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sample_t     sample,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CAL_T:   cal_q.temp <= cfg_data[47:0];
				REG_CAL_PL:  cal_q.pres_lo <= cfg_data;
				REG_CAL_PH:  cal_q.pres_hi <= cfg_data;
				REG_CAL_MIX: cal_q.mix <= cfg_data[47:0];
				REG_CAL_HUM: cal_q.hum <= cfg_data[31:0];
				default:     ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic        f_valid, d_valid, f_dbl, d_dbl;
	logic [31:0] f_num, f_den, d_quo;
	side_t       f_side, d_side;

	hpsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.sample    (sample),
		.cal       (cal_q),
		.out_valid (f_valid),
		.dividend  (f_num),
		.divisor   (f_den),
		.dbl       (f_dbl),
		.side      (f_side)
	);

	hpsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.dividend  (f_num),
		.divisor   (f_den),
		.in_dbl    (f_dbl),
		.in_side   (f_side),
		.out_valid (d_valid),
		.quotient  (d_quo),
		.out_dbl   (d_dbl),
		.out_side  (d_side)
	);

	hpsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.quotient  (d_quo),
		.in_dbl    (d_dbl),
		.in_side   (d_side),
		.cal       (cal_q),
		.out_valid (done),
		.result    (result)
	);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching accepted item");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.pressure_valid) |-> (result.pressure_pa == '0))
		else $error("invalid pressure not forced to zero");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.humidity_q10 <= 17'd102400))
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(result.temperature_centi) >= -15'sd4000
			&& $signed(result.temperature_centi) <= 15'sd8500))
		else $error("temperature out of range");

endmodule
